// ----- design/chip8_fetch_execute_draw_defines.svh -----
// assertion macros used by the chip-8 core design file
// no dependencies
`ifndef CHIP8_FETCH_EXECUTE_DRAW_DEFINES_SVH
`define CHIP8_FETCH_EXECUTE_DRAW_DEFINES_SVH

// same-cycle implication
`define CHIP8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHIP8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/chip8_pkg.sv -----
// types, constants and helpers for the chip-8 core
// no dependencies
package chip8_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_F0, S_F1, S_F2, S_EXEC, S_DY,
    S_DR0, S_DR1, S_DR2, S_CLS, S_RESP
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [11:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] program_counter;
    logic [15:0] opcode;
    logic        collision;
    logic        unimplemented;
  } res_t;

  localparam logic [11:0] PC_START   = 12'h200;
  localparam logic [11:0] FONT_BASE  = 12'h050;
  localparam int          FONT_BYTES = 80;
  localparam logic [15:0] OPC_CLS    = 16'h00E0;

  localparam logic [3:0] NIB_SYS = 4'h0;
  localparam logic [3:0] NIB_JP  = 4'h1;
  localparam logic [3:0] NIB_LD  = 4'h6;
  localparam logic [3:0] NIB_ADD = 4'h7;
  localparam logic [3:0] NIB_LDI = 4'hA;
  localparam logic [3:0] NIB_DRW = 4'hD;
  localparam logic [3:0] REG_VF  = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // remainder by repeated subtraction, quotient at most eight
  function automatic logic [12:0] mod_fold(input logic [12:0] v, input logic [12:0] m);
    logic [12:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

endpackage

// ----- design/chip8_fetch_execute_draw.sv -----
// chip-8 core: fetch, execute and sprite draw over program and display rams
// depends on chip8_pkg, chip8_ram and chip8_fetch_execute_draw_defines.svh
// A memory write or an unknown operation gives its result in the cycle after
// the transfer, a display read once the display ram has been read (sooner when
// the byte index is out of range), an instruction after its two fetch reads and
// execute, a draw after that and one sprite row read and one or two display
// bytes written per row, and a screen clear after a sweep of the display ram,
// all set by the single read port of each ram. After reset the display ram is
// swept clear, one byte a cycle, with busy high. A result is shown on res_o for
// the one cycle that done_o is high and the receiver cannot hold it off.
`include "chip8_fetch_execute_draw_defines.svh"

module chip8_fetch_execute_draw #(
  parameter int MEMORY_BYTES  = 4096,
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  chip8_pkg::item_t    item_i,
  output logic                done_o,
  output chip8_pkg::res_t     res_o
);

  localparam int MAW      = $clog2(MEMORY_BYTES);
  localparam int BPR      = SCREEN_WIDTH / 8;
  localparam int FB_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int FAW      = $clog2(FB_BYTES);
  localparam int XW       = $clog2(SCREEN_WIDTH);
  localparam int HW       = $clog2(SCREEN_HEIGHT);
  localparam int YW       = $clog2(SCREEN_HEIGHT + 16);

  chip8_pkg::state_e state_q, state_d;

  logic [11:0] pc_q, idx_q, ma_q, ma_d;
  logic [7:0]  v_q [16];
  logic [chip8_pkg::FONT_BYTES-1:0] fw_q;
  logic        unimpl_q, hit_q;
  logic [7:0]  rd_q, lo_q;
  logic [15:0] op_q;
  logic [FAW-1:0] cnt_q, b0_q;
  logic [3:0]  row_q;
  logic [XW-1:0] x0_q;
  logic [HW-1:0] y0_q;

  logic           accept;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_rdata, mem_byte;
  logic           fb_we;
  logic [FAW-1:0] fb_waddr, fb_raddr;
  logic [7:0]     fb_wdata, fb_rdata;

  logic [11:0] wr_slot, slot_in, font_off;
  logic [3:0]  rsel;
  logic [7:0]  rval;
  logic [YW-1:0] yr;
  logic        row_ok;
  logic [FAW-1:0] b0;
  logic [15:0] spr;
  logic        has_b1;
  logic [3:0]  nib_x, nib_y, nib_n;

  assign accept = start && !busy;
  assign busy   = (state_q != chip8_pkg::S_IDLE);
  assign done_o = (state_q == chip8_pkg::S_RESP);
  assign nib_x  = op_q[11:8];
  assign nib_y  = op_q[7:4];
  assign nib_n  = op_q[3:0];

  assign wr_slot = 12'(chip8_pkg::mod_fold({1'b0, item_i.address}, 13'(MEMORY_BYTES)));
  assign rsel = (state_q == chip8_pkg::S_DY) ? nib_y : nib_x;
  assign rval = v_q[rsel];
  assign yr   = YW'(y0_q) + YW'(row_q);
  assign row_ok = (row_q < nib_n) && (32'(yr) < SCREEN_HEIGHT);
  assign b0   = FAW'(32'(yr) * BPR + 32'(x0_q[XW-1:3]));
  assign spr  = {mem_byte, 8'h00} >> x0_q[2:0];
  assign has_b1 = (32'(x0_q[XW-1:3]) != BPR - 1);

  // font bytes read from their table until overwritten
  assign font_off = ma_q - chip8_pkg::FONT_BASE;
  always_comb begin
    mem_byte = mem_rdata;
    if (ma_q >= chip8_pkg::FONT_BASE &&
        32'(ma_q) < 32'(chip8_pkg::FONT_BASE) + chip8_pkg::FONT_BYTES &&
        !fw_q[font_off[6:0]]) begin
      mem_byte = chip8_pkg::FONT[font_off[6:0]];
    end
  end

  chip8_ram #(.Width(8), .Depth(MEMORY_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (item_i.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  chip8_ram #(.Width(8), .Depth(FB_BYTES)) u_fb (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chip8_pkg::S_INIT: if (32'(cnt_q) == FB_BYTES - 1) state_d = chip8_pkg::S_IDLE;
      chip8_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item_i.operation)
            chip8_pkg::OP_EXEC: state_d = chip8_pkg::S_F0;
            chip8_pkg::OP_READ: state_d = (32'(item_i.address) < FB_BYTES) ?
                                          chip8_pkg::S_RD : chip8_pkg::S_RESP;
            default:            state_d = chip8_pkg::S_RESP;
          endcase
        end
      end
      chip8_pkg::S_RD:   state_d = chip8_pkg::S_RESP;
      chip8_pkg::S_F0:   state_d = chip8_pkg::S_F1;
      chip8_pkg::S_F1:   state_d = chip8_pkg::S_F2;
      chip8_pkg::S_F2:   state_d = chip8_pkg::S_EXEC;
      chip8_pkg::S_EXEC: begin
        if (op_q == chip8_pkg::OPC_CLS) state_d = chip8_pkg::S_CLS;
        else if (op_q[15:12] == chip8_pkg::NIB_DRW) state_d = chip8_pkg::S_DY;
        else state_d = chip8_pkg::S_RESP;
      end
      chip8_pkg::S_DY:   state_d = chip8_pkg::S_DR0;
      chip8_pkg::S_DR0:  state_d = row_ok ? chip8_pkg::S_DR1 : chip8_pkg::S_RESP;
      chip8_pkg::S_DR1:  state_d = has_b1 ? chip8_pkg::S_DR2 : chip8_pkg::S_DR0;
      chip8_pkg::S_DR2:  state_d = chip8_pkg::S_DR0;
      chip8_pkg::S_CLS:  if (32'(cnt_q) == FB_BYTES - 1) state_d = chip8_pkg::S_RESP;
      chip8_pkg::S_RESP: state_d = chip8_pkg::S_IDLE;
      default:           state_d = chip8_pkg::S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    slot_in   = 12'h000;
    ma_d      = ma_q;
    mem_we    = 1'b0;
    mem_waddr = wr_slot[MAW-1:0];
    fb_we     = 1'b0;
    fb_waddr  = cnt_q;
    fb_wdata  = 8'h00;
    fb_raddr  = b0_q;
    unique case (state_q)
      chip8_pkg::S_INIT, chip8_pkg::S_CLS: fb_we = 1'b1;
      chip8_pkg::S_IDLE: begin
        mem_we   = accept && (item_i.operation == chip8_pkg::OP_WRITE);
        fb_raddr = item_i.address[FAW-1:0];
      end
      chip8_pkg::S_F0:  slot_in = pc_q;
      chip8_pkg::S_F1:  slot_in = pc_q + 12'd1;
      chip8_pkg::S_DR0: begin
        slot_in  = idx_q + 12'(row_q);
        fb_raddr = b0;
      end
      chip8_pkg::S_DR1: begin
        fb_we    = 1'b1;
        fb_waddr = b0_q;
        fb_wdata = fb_rdata ^ spr[15:8];
        fb_raddr = b0_q + FAW'(1);
      end
      chip8_pkg::S_DR2: begin
        fb_we    = 1'b1;
        fb_waddr = b0_q + FAW'(1);
        fb_wdata = fb_rdata ^ lo_q;
      end
      default: ;
    endcase
    if (state_q == chip8_pkg::S_F0 || state_q == chip8_pkg::S_F1 ||
        state_q == chip8_pkg::S_DR0) begin
      ma_d = 12'(chip8_pkg::mod_fold({1'b0, slot_in}, 13'(MEMORY_BYTES)));
    end
    mem_raddr = ma_d[MAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= chip8_pkg::S_INIT;
      pc_q     <= chip8_pkg::PC_START;
      idx_q    <= 12'h000;
      v_q      <= '{default: 8'h00};
      fw_q     <= '0;
      cnt_q    <= '0;
      unimpl_q <= 1'b0;
      rd_q     <= 8'h00;
      op_q     <= 16'h0000;
    end else begin
      state_q <= state_d;
      if (fb_we && (state_q == chip8_pkg::S_INIT || state_q == chip8_pkg::S_CLS)) begin
        cnt_q <= cnt_q + FAW'(1);
      end
      unique case (state_q)
        chip8_pkg::S_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            unimpl_q <= 1'b0;
            rd_q     <= 8'h00;
            op_q     <= 16'h0000;
            if (mem_we && wr_slot >= chip8_pkg::FONT_BASE &&
                32'(wr_slot) < 32'(chip8_pkg::FONT_BASE) + chip8_pkg::FONT_BYTES) begin
              fw_q[7'(wr_slot - chip8_pkg::FONT_BASE)] <= 1'b1;
            end
          end
        end
        chip8_pkg::S_RD: rd_q <= fb_rdata;
        chip8_pkg::S_F1: op_q[15:8] <= mem_byte;
        chip8_pkg::S_F2: begin
          op_q[7:0] <= mem_byte;
          pc_q      <= pc_q + 12'd2;
        end
        chip8_pkg::S_EXEC: begin
          unique case (op_q[15:12])
            chip8_pkg::NIB_SYS: unimpl_q <= (op_q != chip8_pkg::OPC_CLS);
            chip8_pkg::NIB_JP:  pc_q <= op_q[11:0];
            chip8_pkg::NIB_LD:  v_q[nib_x] <= op_q[7:0];
            chip8_pkg::NIB_ADD: v_q[nib_x] <= rval + op_q[7:0];
            chip8_pkg::NIB_LDI: idx_q <= op_q[11:0];
            chip8_pkg::NIB_DRW: x0_q <= XW'(chip8_pkg::mod_fold(13'(rval),
                                                                13'(SCREEN_WIDTH)));
            default:            unimpl_q <= 1'b1;
          endcase
        end
        chip8_pkg::S_DY: begin
          y0_q  <= HW'(chip8_pkg::mod_fold(13'(rval), 13'(SCREEN_HEIGHT)));
          row_q <= 4'd0;
          hit_q <= 1'b0;
          v_q[chip8_pkg::REG_VF] <= 8'h00;
        end
        chip8_pkg::S_DR0: begin
          ma_q <= ma_d;
          b0_q <= b0;
          if (!row_ok) v_q[chip8_pkg::REG_VF] <= {7'd0, hit_q};
        end
        chip8_pkg::S_DR1: begin
          lo_q  <= spr[7:0];
          hit_q <= hit_q | (|(fb_rdata & spr[15:8]));
          if (!has_b1) row_q <= row_q + 4'd1;
        end
        chip8_pkg::S_DR2: begin
          hit_q <= hit_q | (|(fb_rdata & lo_q));
          row_q <= row_q + 4'd1;
        end
        default: ;
      endcase
      if (state_q == chip8_pkg::S_F0 || state_q == chip8_pkg::S_F1) ma_q <= ma_d;
    end
  end

  assign res_o.read_data       = rd_q;
  assign res_o.program_counter = pc_q;
  assign res_o.opcode          = op_q;
  assign res_o.collision       = v_q[chip8_pkg::REG_VF][0];
  assign res_o.unimplemented   = unimpl_q;

  `CHIP8_ASSERT_NXT(a_done_one_cycle, done_o, !done_o, "result strobe longer than one cycle")
  `CHIP8_ASSERT_NXT(a_accept_busy, accept, busy, "transfer taken without going busy")
  `CHIP8_ASSERT_IMP(a_fb_range, fb_we, 32'(fb_waddr) < FB_BYTES, "display write out of range")
  `CHIP8_ASSERT_IMP(a_cls_impl, done_o && res_o.opcode == chip8_pkg::OPC_CLS,
                    !res_o.unimplemented, "clear screen flagged unimplemented")

endmodule

// ----- design/chip8_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module chip8_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- verif/chip8_fetch_execute_draw_tb.sv -----
// testbench for the chip-8 core: directed and random program, execute and display traffic
// checked against an in-bench predictor of memory, display, registers, index and pc
// depends on chip8_pkg and the chip8_fetch_execute_draw design files
`timescale 1ns / 1ps

module chip8_fetch_execute_draw_tb;

  localparam int LIMIT = 4000;
  localparam int SETTLE = 80;
  localparam int RANDOM_ITEMS = 1600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  chip8_pkg::item_t item_i = '0;
  logic done_o;
  chip8_pkg::res_t res_o;

  chip8_fetch_execute_draw dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .res_o(res_o)
  );

  always #6 clk_i = ~clk_i;

  // predicted machine state
  logic [7:0] mem_q [4096];
  bit written_q [4096];
  bit [2047:0] pixels_q;
  logic [7:0] vreg_q [16];
  logic [11:0] index_q;
  logic [11:0] pc_q;

  chip8_pkg::res_t pending_q [$];
  int errors = 0;
  int sent = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic chip8_pkg::res_t cpu_step(input chip8_pkg::item_t it);
    chip8_pkg::res_t r;
    logic [15:0] word;
    logic [7:0] vx, vy, line;
    int x0, y0, n, base;
    bit hit;
    r = '0;
    r.program_counter = pc_q;
    case (it.operation)
      chip8_pkg::OP_WRITE: begin
        mem_q[it.address] = it.data;
        written_q[it.address] = 1'b1;
      end
      chip8_pkg::OP_EXEC: begin
        word = {mem_q[pc_q], mem_q[pc_q + 12'd1]};
        pc_q = pc_q + 12'd2;
        case (word[15:12])
          chip8_pkg::NIB_SYS: begin
            if (word == chip8_pkg::OPC_CLS) pixels_q = '0;
            else r.unimplemented = 1'b1;
          end
          chip8_pkg::NIB_JP:  pc_q = word[11:0];
          chip8_pkg::NIB_LD:  vreg_q[word[11:8]] = word[7:0];
          chip8_pkg::NIB_ADD: vreg_q[word[11:8]] = vreg_q[word[11:8]] + word[7:0];
          chip8_pkg::NIB_LDI: index_q = word[11:0];
          chip8_pkg::NIB_DRW: begin
            vx = vreg_q[word[11:8]];
            vy = vreg_q[word[7:4]];
            x0 = int'(vx) % 64;
            y0 = int'(vy) % 32;
            n = int'(word[3:0]);
            hit = 1'b0;
            for (int row = 0; row < n; row++) begin
              if (y0 + row >= 32) break;
              line = mem_q[index_q + 12'(row)];
              for (int c = 0; c < 8; c++) begin
                if (x0 + c >= 64) break;
                if (line[7 - c]) begin
                  if (pixels_q[(y0 + row) * 64 + x0 + c]) hit = 1'b1;
                  pixels_q[(y0 + row) * 64 + x0 + c] ^= 1'b1;
                end
              end
            end
            vreg_q[chip8_pkg::REG_VF] = {7'd0, hit};
          end
          default: r.unimplemented = 1'b1;
        endcase
        r.opcode = word;
        r.program_counter = pc_q;
      end
      chip8_pkg::OP_READ: begin
        if (it.address < 256) begin
          base = (int'(it.address) / 8) * 64 + (int'(it.address) % 8) * 8;
          for (int c = 0; c < 8; c++) r.read_data[7 - c] = pixels_q[base + c];
        end
      end
      default: ;
    endcase
    r.collision = vreg_q[chip8_pkg::REG_VF][0];
    return r;
  endfunction

  task automatic send(input chip8_pkg::op_e op, input logic [11:0] addr,
                      input logic [7:0] data);
    chip8_pkg::item_t it;
    it.operation = op;
    it.address = addr;
    it.data = data;
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(cpu_step(it));
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic bit sprite_ready(input logic [3:0] n);
    for (int row = 0; row < n; row++)
      if (!written_q[index_q + 12'(row)]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fill_sprite(input logic [3:0] n);
    for (int row = 0; row < n; row++)
      if (!written_q[index_q + 12'(row)])
        send(chip8_pkg::OP_WRITE, index_q + 12'(row), 8'($urandom));
  endtask

  // place an instruction at pc, after writing any missing sprite rows for a draw, and run it
  task automatic run_instr(input logic [15:0] word);
    logic [11:0] at;
    if (word[15:12] == chip8_pkg::NIB_DRW) fill_sprite(word[3:0]);
    at = pc_q;
    send(chip8_pkg::OP_WRITE, at, word[15:8]);
    send(chip8_pkg::OP_WRITE, at + 12'd1, word[7:0]);
    send(chip8_pkg::OP_EXEC, '0, '0);
  endtask

  always @(posedge clk_i) begin
    chip8_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (res_o.read_data !== want.read_data)
          report($sformatf("read_data %h want %h", res_o.read_data, want.read_data));
        if (res_o.program_counter !== want.program_counter)
          report($sformatf("pc %h want %h", res_o.program_counter, want.program_counter));
        if (res_o.opcode !== want.opcode)
          report($sformatf("opcode %h want %h", res_o.opcode, want.opcode));
        if (res_o.collision !== want.collision)
          report($sformatf("collision %b want %b", res_o.collision, want.collision));
        if (res_o.unimplemented !== want.unimplemented)
          report($sformatf("unimpl %b want %b", res_o.unimplemented, want.unimplemented));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_display_and_memory;
    send(chip8_pkg::OP_READ, 12'd0, 8'd0);
    send(chip8_pkg::OP_READ, 12'd255, 8'd0);
    send(chip8_pkg::OP_READ, 12'd256, 8'd0);
    send(chip8_pkg::OP_READ, 12'hFFF, 8'hFF);
    send(chip8_pkg::OP_WRITE, 12'hFFF, 8'hFF);
    send(chip8_pkg::OP_WRITE, 12'h000, 8'h00);
    send(chip8_pkg::OP_NOP, 12'hFFF, 8'hFF);
  endtask

  task automatic test_instructions;
    run_instr(16'h6A3F);
    run_instr(16'h7AFF);
    run_instr(16'h6B1F);
    run_instr({chip8_pkg::NIB_LDI, chip8_pkg::FONT_BASE + 12'd40});
    run_instr(16'hDAB5);
    run_instr(16'hDAB5);
    run_instr(16'h6F7C);
    run_instr(16'hDFF5);
    send(chip8_pkg::OP_READ, 12'd255, 8'd0);
    run_instr(16'h00EE);
    run_instr(16'h0123);
    run_instr(16'hF00A);
    run_instr(16'h00E0);
    run_instr(16'h1FFE);
    run_instr(16'h12F0);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: w[15:12] = chip8_pkg::NIB_DRW;
      6, 7, 8:          w[15:12] = chip8_pkg::NIB_LD;
      9, 10:            w[15:12] = chip8_pkg::NIB_ADD;
      11:               w = {chip8_pkg::NIB_LDI,
                             chip8_pkg::FONT_BASE + 12'($urandom_range(0, 79))};
      12:               w[15:12] = chip8_pkg::NIB_LDI;
      13:               w[15:12] = chip8_pkg::NIB_JP;
      14:               w = chip8_pkg::OPC_CLS;
      15:               w[15:12] = chip8_pkg::NIB_SYS;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_random;
    logic [15:0] w;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (sent > RANDOM_ITEMS - 200) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: send(chip8_pkg::OP_WRITE, 12'($urandom), 8'($urandom));
        1, 2: send(chip8_pkg::OP_READ, $urandom_range(0, 9) == 0 ? 12'($urandom)
                                       : 12'($urandom_range(0, 255)), 8'($urandom));
        3: send(chip8_pkg::OP_NOP, 12'($urandom), 8'($urandom));
        4: begin
          w = {mem_q[pc_q], mem_q[pc_q + 12'd1]};
          if (written_q[pc_q] && written_q[pc_q + 12'd1] &&
              (w[15:12] != chip8_pkg::NIB_DRW || sprite_ready(w[3:0])))
            send(chip8_pkg::OP_EXEC, 12'($urandom), 8'($urandom));
          else
            run_instr(random_opcode());
        end
        default: run_instr(random_opcode());
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) begin
      mem_q[i] = '0;
      written_q[i] = 1'b0;
    end
    for (int i = 0; i < chip8_pkg::FONT_BYTES; i++) begin
      mem_q[chip8_pkg::FONT_BASE + i] = chip8_pkg::FONT[i];
      written_q[chip8_pkg::FONT_BASE + i] = 1'b1;
    end
    pixels_q = '0;
    for (int i = 0; i < 16; i++) vreg_q[i] = '0;
    index_q = '0;
    pc_q = chip8_pkg::PC_START;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_display_and_memory();
    test_instructions();
    test_random();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
